[rtl/mbw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbw_pkg
// Shared constants, operation codes and controller/datapath link types for
// the MSB-first bit writer.
// ----------------------------------------------------------------------------
package mbw_pkg;

  localparam int MAX_LITERAL_BITS_DEF = 32;
  localparam int VALUE_BITS           = 32;
  localparam int COUNT_BITS           = 6;
  localparam int BYTE_BITS            = 8;
  localparam int WORD_BITS            = VALUE_BITS + BYTE_BITS;
  localparam int FILL_BITS            = 3;
  localparam int PEND_BITS            = 3;
  localparam int TOTAL_BITS           = 24;

  localparam logic [TOTAL_BITS-1:0] COUNT_MAX = '1;
  localparam logic [BYTE_BITS-1:0]  STOP_BIT  = 8'h80;

  localparam logic [1:0] OP_LITERAL  = 2'd0;
  localparam logic [1:0] OP_TRAILING = 2'd1;
  localparam logic [1:0] OP_FINISH   = 2'd2;

  typedef struct packed {
    logic load_lit;
    logic load_trail;
    logic emit_byte;
    logic emit_finish;
  } cmd_t;

  typedef struct packed {
    logic pend_zero;
    logic pend_one;
    logic slot_free;
  } status_t;

endpackage : mbw_pkg
`default_nettype wire

[rtl/mbw_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbw_ctrl
// Controller: takes one transaction at a time, sequences byte emission and
// the finish result.
// ----------------------------------------------------------------------------
module mbw_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      operation,
  input  wire mbw_pkg::status_t status,
  output mbw_pkg::cmd_t        cmd
);
  import mbw_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    EMIT,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == IDLE);
    case (state)
      IDLE: begin
        if (in_valid) begin
          case (operation)
            OP_LITERAL: begin
              cmd.load_lit = 1'b1;
              state_next   = EMIT;
            end
            OP_TRAILING: begin
              cmd.load_trail = 1'b1;
              state_next     = EMIT;
            end
            OP_FINISH: begin
              state_next = FINISH;
            end
            default: begin
              state_next = IDLE;
            end
          endcase
        end
      end
      EMIT: begin
        cmd.emit_byte = status.slot_free && !status.pend_zero;
        if (status.pend_zero || (status.pend_one && status.slot_free)) begin
          state_next = IDLE;
        end
      end
      FINISH: begin
        cmd.emit_finish = status.slot_free;
        if (status.slot_free) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : mbw_ctrl
`default_nettype wire

[rtl/mbw_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbw_datapath
// Datapath: bit packing word, fill and byte counters, and the output register.
// ----------------------------------------------------------------------------
module mbw_datapath #(
  parameter int MAX_LITERAL_BITS = mbw_pkg::MAX_LITERAL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [mbw_pkg::VALUE_BITS-1:0] value,
  input  wire logic [mbw_pkg::COUNT_BITS-1:0] bit_count,
  input  wire mbw_pkg::cmd_t                  cmd,
  output mbw_pkg::status_t                    status,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mbw_pkg::BYTE_BITS-1:0]       byte_value,
  output logic                                byte_valid,
  output logic                                last,
  output logic [mbw_pkg::TOTAL_BITS-1:0]      bytes_written
);
  import mbw_pkg::*;

  localparam int CAP = (MAX_LITERAL_BITS < VALUE_BITS) ? MAX_LITERAL_BITS : VALUE_BITS;
  localparam logic [COUNT_BITS-1:0] CAP_W = COUNT_BITS'(CAP);
  localparam logic [COUNT_BITS-1:0] VALUE_W = COUNT_BITS'(VALUE_BITS);

  logic [WORD_BITS-1:0]  word;
  logic [FILL_BITS-1:0]  fill;
  logic [PEND_BITS-1:0]  pend;
  logic [TOTAL_BITS-1:0] total;

  logic [COUNT_BITS-1:0] count_cap;
  logic [VALUE_BITS-1:0] lit;
  logic [WORD_BITS-1:0]  lit_word;
  logic [COUNT_BITS-1:0] bits_sum;
  logic [TOTAL_BITS-1:0] total_inc;
  logic [BYTE_BITS-1:0]  head;
  logic                  take;

  assign head      = word[WORD_BITS-1 -: BYTE_BITS];
  assign count_cap = (bit_count > CAP_W) ? CAP_W : bit_count;
  assign lit       = value << (VALUE_W - count_cap);
  assign lit_word  = {lit, {BYTE_BITS{1'b0}}} >> fill;
  assign bits_sum  = {{(COUNT_BITS-FILL_BITS){1'b0}}, fill} + count_cap;
  assign total_inc = (total == COUNT_MAX) ? total : total + 1'b1;
  assign take      = out_valid && out_ready;

  assign status.pend_zero = (pend == '0);
  assign status.pend_one  = (pend == PEND_BITS'(1));
  assign status.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word      <= '0;
      fill      <= '0;
      pend      <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_byte || cmd.emit_finish) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
      if (cmd.load_lit) begin
        word <= {head, {VALUE_BITS{1'b0}}} | lit_word;
        pend <= bits_sum[COUNT_BITS-1 -: PEND_BITS];
        fill <= bits_sum[FILL_BITS-1:0];
      end else if (cmd.load_trail) begin
        word <= {head | (STOP_BIT >> fill), {VALUE_BITS{1'b0}}};
        pend <= PEND_BITS'(1);
        fill <= '0;
      end else if (cmd.emit_byte) begin
        word      <= word << BYTE_BITS;
        pend      <= pend - 1'b1;
        total     <= total_inc;
      end else if (cmd.emit_finish) begin
        word      <= '0;
        fill      <= '0;
        total     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      byte_value    <= head;
      byte_valid    <= 1'b1;
      last          <= 1'b0;
      bytes_written <= total_inc;
    end else if (cmd.emit_finish) begin
      byte_value    <= (fill != '0) ? head : '0;
      byte_valid    <= (fill != '0);
      last          <= 1'b1;
      bytes_written <= (fill != '0) ? total_inc : total;
    end
  end

endmodule : mbw_datapath
`default_nettype wire

[rtl/msb_first_bit_writer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_writer
// Packs literals MSB first into bytes; trailing-bits and finish transactions
// close the buffer.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid/in_ready, operation, value, bit_count | to block
//   out     | out_valid/out_ready, byte_value, byte_valid,   | from block
//           | last, bytes_written                            |
//
// A literal emits each byte it completes (up to four), a trailing transaction
// the padded byte, a finish its result; an unused code emits nothing. Unless
// the output stalls, one byte per cycle leaves by the single output register.
// Reset clears the partial byte, fill and byte count; no clearing pass.
// A stalled output holds the emission sequence; no input is taken meanwhile.
// ----------------------------------------------------------------------------
module msb_first_bit_writer #(
  parameter int MAX_LITERAL_BITS = mbw_pkg::MAX_LITERAL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     operation,
  input  wire logic [mbw_pkg::VALUE_BITS-1:0] value,
  input  wire logic [mbw_pkg::COUNT_BITS-1:0] bit_count,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mbw_pkg::BYTE_BITS-1:0]       byte_value,
  output logic                                byte_valid,
  output logic                                last,
  output logic [mbw_pkg::TOTAL_BITS-1:0]      bytes_written
);
  import mbw_pkg::*;

  cmd_t    cmd;
  status_t status;

  mbw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  mbw_datapath #(
    .MAX_LITERAL_BITS (MAX_LITERAL_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .value         (value),
    .bit_count     (bit_count),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_value    (byte_value),
    .byte_valid    (byte_valid),
    .last          (last),
    .bytes_written (bytes_written)
  );

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> status.pend_zero)
    else $error("input ready while bytes are pending");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  a_empty_finish: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (last && byte_value == '0))
    else $error("empty result that is not a clean finish");

  a_emit_after_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_byte || cmd.emit_finish) |=> out_valid)
    else $error("emitted transaction not presented");

endmodule : msb_first_bit_writer
`default_nettype wire
